// ----- src/mfir_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfir_pkg
// Shared sizes, codes and controller-to-datapath types for the multichannel
// FIR filter unit.
// ----------------------------------------------------------------------------
package mfir_pkg;

    // Storage limits and the widths that follow from them.
    localparam int MAX_TAPS     = 256;
    localparam int MAX_CHANNELS = 8;
    localparam int TAP_W        = $clog2(MAX_TAPS);
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int HIST_DEPTH   = MAX_TAPS * MAX_CHANNELS;
    localparam int HIST_AW      = $clog2(HIST_DEPTH);

    // Field widths of the channels and registers.
    localparam int SAMPLE_W     = 24;
    localparam int COEF_W       = 24;
    localparam int FUNC_W       = 2;
    localparam int TAP_IDX_W    = 8;
    localparam int CHAN_OUT_W   = 3;
    localparam int CHAN_CNT_W   = 4;
    localparam int TAP_CNT_W    = 9;
    localparam int LAT_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // Arithmetic: exact products summed over up to MAX_TAPS terms.
    localparam int PROD_W       = SAMPLE_W + COEF_W;
    localparam int ACC_W        = PROD_W + TAP_W + 1;
    localparam int FRAC_SHIFT   = 22;
    localparam int SAT_MAX      = 8388607;
    localparam int SAT_MIN      = -8388608;

    // Operation codes of an input transaction.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_COEF   = 2'd1,
        FUNC_CLEAR  = 2'd2
    } t_func;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNELS = 2'd0,
        CFG_TAPS     = 2'd1,
        CFG_LATENCY  = 2'd2
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                  hist_we;
        logic [HIST_AW-1:0]    hist_waddr;
        logic                  coef_we;
        logic [TAP_W-1:0]      coef_waddr;
        logic                  rd_en;
        logic [HIST_AW-1:0]    hist_raddr;
        logic [TAP_W-1:0]      coef_raddr;
        logic                  acc_clr;
        logic                  out_load;
        logic [CHAN_OUT_W-1:0] out_channel;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- src/mfir_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfir_in_if
// Input channel: valid/ready handshake carrying one operation per transaction.
// ----------------------------------------------------------------------------
interface mfir_in_if
    import mfir_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic [FUNC_W-1:0]           func;
    logic signed [SAMPLE_W-1:0]  sample_in;
    logic [TAP_IDX_W-1:0]        tap_index;
    logic signed [COEF_W-1:0]    coef_value;

    modport source (output valid, func, sample_in, tap_index, coef_value, input ready);
    modport sink   (input valid, func, sample_in, tap_index, coef_value, output ready);
endinterface

// ----- src/mfir_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfir_out_if
// Output channel: valid/ready handshake carrying one filtered sample.
// ----------------------------------------------------------------------------
interface mfir_out_if
    import mfir_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_W-1:0]  sample_out;
    logic [CHAN_OUT_W-1:0]       channel;

    modport source (output valid, sample_out, channel, input ready);
    modport sink   (input valid, sample_out, channel, output ready);
endinterface

// ----- src/mfir_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfir_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mfir_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/mfir_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfir_ctrl
// Controller: configuration registers, stream counters and the sequencer that
// steps the shared multiply-accumulate through the taps of one sample.
// ----------------------------------------------------------------------------
module mfir_ctrl
    import mfir_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic [FUNC_W-1:0]     i_in_func,
    input  logic [TAP_IDX_W-1:0]  i_in_tap_index,
    output logic                  o_in_ready,
    input  t_dp_sts               i_sts,
    output t_dp_cmd               o_cmd
);
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MAC    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [CHAN_CNT_W-1:0] r_chan_cnt;
    logic [TAP_CNT_W-1:0]  r_tap_cnt;
    logic [LAT_W-1:0]      r_lat;
    logic [TAP_W-1:0]      r_wpos, n_wpos;
    logic [CH_W-1:0]       r_cur, n_cur;
    logic [TAP_W:0]        r_valid, n_valid;
    logic [LAT_W-1:0]      r_dropped, n_dropped;
    logic [CH_W-1:0]       r_ch, n_ch;
    logic [TAP_W-1:0]      r_pos, n_pos;
    logic [TAP_W-1:0]      r_u, n_u;
    logic [TAP_W-1:0]      r_last, n_last;
    logic                  r_emit, n_emit;

    logic                  accept;
    logic [CHAN_CNT_W-1:0] eff_ch;
    logic [TAP_CNT_W-1:0]  eff_taps;
    logic [TAP_W+1:0]      valid_p1;
    logic [TAP_W+1:0]      n_taps;
    logic [CH_W-1:0]       cur_ch;
    logic                  frame_end;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Effective channel and tap counts, clamped into the supported range.
    always_comb begin
        if (r_chan_cnt == '0) begin
            eff_ch = CHAN_CNT_W'(1);
        end else if (r_chan_cnt > CHAN_CNT_W'(MAX_CHANNELS)) begin
            eff_ch = CHAN_CNT_W'(MAX_CHANNELS);
        end else begin
            eff_ch = r_chan_cnt;
        end
        if (r_tap_cnt == '0) begin
            eff_taps = TAP_CNT_W'(1);
        end else if (r_tap_cnt > TAP_CNT_W'(MAX_TAPS)) begin
            eff_taps = TAP_CNT_W'(MAX_TAPS);
        end else begin
            eff_taps = r_tap_cnt;
        end
    end

    // Channel of this sample, number of taps to walk and frame boundary.
    always_comb begin
        cur_ch    = ({1'b0, r_cur} >= CH_W'(0) + eff_ch) ? '0 : r_cur;
        valid_p1  = {1'b0, r_valid} + (TAP_W + 2)'(1);
        n_taps    = ((TAP_W + 2)'(eff_taps) < valid_p1) ? (TAP_W + 2)'(eff_taps) : valid_p1;
        frame_end = ({1'b0, cur_ch} + CHAN_CNT_W'(1)) >= eff_ch;
    end

    // Configuration registers; the user is to write them only while idle, the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt <= CHAN_CNT_W'(1);
            r_tap_cnt  <= TAP_CNT_W'(1);
            r_lat      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHANNELS: r_chan_cnt <= i_cfg_data[CHAN_CNT_W-1:0];
                CFG_TAPS:     r_tap_cnt  <= i_cfg_data[TAP_CNT_W-1:0];
                CFG_LATENCY:  r_lat      <= i_cfg_data[LAT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and stream counters.
    always_comb begin
        n_state   = r_state;
        n_wpos    = r_wpos;
        n_cur     = r_cur;
        n_valid   = r_valid;
        n_dropped = r_dropped;
        n_ch      = r_ch;
        n_pos     = r_pos;
        n_u       = r_u;
        n_last    = r_last;
        n_emit    = r_emit;

        o_cmd             = '0;
        o_cmd.hist_waddr  = {cur_ch, r_wpos};
        o_cmd.coef_waddr  = i_in_tap_index[TAP_W-1:0];
        o_cmd.hist_raddr  = {r_ch, r_pos - r_u};
        o_cmd.coef_raddr  = r_u;
        o_cmd.out_channel = CHAN_OUT_W'(r_ch);

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_in_func)
                        FUNC_SAMPLE: begin
                            // Store the sample and start a new sum.
                            o_cmd.hist_we = 1'b1;
                            o_cmd.acc_clr = 1'b1;
                            n_ch    = cur_ch;
                            n_pos   = r_wpos;
                            n_u     = '0;
                            n_last  = TAP_W'(n_taps - (TAP_W + 2)'(1));
                            n_emit  = (r_dropped >= r_lat);
                            n_state = ST_MAC;
                            if (frame_end) begin
                                n_cur  = '0;
                                n_wpos = r_wpos + TAP_W'(1);
                                if (r_valid < (TAP_W + 1)'(MAX_TAPS)) begin
                                    n_valid = r_valid + (TAP_W + 1)'(1);
                                end
                                if (r_dropped < r_lat) begin
                                    n_dropped = r_dropped + LAT_W'(1);
                                end
                            end else begin
                                n_cur = cur_ch + CH_W'(1);
                            end
                        end
                        FUNC_COEF: begin
                            o_cmd.coef_we = 1'b1;
                        end
                        FUNC_CLEAR: begin
                            n_wpos    = '0;
                            n_cur     = '0;
                            n_valid   = '0;
                            n_dropped = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAC: begin
                // Issue one tap read per cycle.
                o_cmd.rd_en = 1'b1;
                n_u         = r_u + TAP_W'(1);
                if (r_u == r_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_emit) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wpos    <= '0;
            r_cur     <= '0;
            r_valid   <= '0;
            r_dropped <= '0;
            r_emit    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wpos    <= n_wpos;
            r_cur     <= n_cur;
            r_valid   <= n_valid;
            r_dropped <= n_dropped;
            r_emit    <= n_emit;
        end
    end

    // Per-sample working registers.
    always_ff @(posedge i_clk) begin
        r_ch   <= n_ch;
        r_pos  <= n_pos;
        r_u    <= n_u;
        r_last <= n_last;
    end
endmodule

// ----- src/mfir_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfir_dp
// Datapath: history and coefficient memories, the shared multiplier, the
// accumulator, rounding with saturation and the output register.
// ----------------------------------------------------------------------------
module mfir_dp
    import mfir_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_sts                    o_sts,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic signed [COEF_W-1:0]   i_coef_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic [CHAN_OUT_W-1:0]      o_channel
);
    logic [SAMPLE_W-1:0]        hist_rdata;
    logic [COEF_W-1:0]          coef_rdata;
    logic                       r_rd_vld;
    logic                       r_prod_vld;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    rounded;
    logic signed [SAMPLE_W-1:0] n_result;
    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic [CHAN_OUT_W-1:0]      r_out_channel;

    // Per-channel sample history.
    mfir_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.hist_we),
        .i_waddr (i_cmd.hist_waddr),
        .i_wdata (i_sample_in),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.hist_raddr),
        .o_rdata (hist_rdata)
    );

    // Filter kernel.
    mfir_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.coef_we),
        .i_waddr (i_cmd.coef_waddr),
        .i_wdata (i_coef_value),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.coef_raddr),
        .o_rdata (coef_rdata)
    );

    // Pipeline valid flags for the read and multiply stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.rd_en;
            r_prod_vld <= r_rd_vld;
        end
    end

    // Registered product, then accumulation.
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_prod <= PROD_W'($signed(hist_rdata) * $signed(coef_rdata));
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round half up to Q1.23, then saturate.
    always_comb begin
        rounded = (r_acc + (ACC_W'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        if (rounded > ACC_W'(SAT_MAX)) begin
            n_result = SAMPLE_W'(SAT_MAX);
        end else if (rounded < ACC_W'(SAT_MIN)) begin
            n_result = SAMPLE_W'(SAT_MIN);
        end else begin
            n_result = rounded[SAMPLE_W-1:0];
        end
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sample  <= n_result;
            r_out_channel <= i_cmd.out_channel;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_sample_out    = r_out_sample;
    assign o_channel       = r_out_channel;
    assign o_sts.pipe_busy = r_rd_vld || r_prod_vld;
    assign o_sts.out_free  = !r_out_vld || i_out_ready;
endmodule

// ----- src/multichannel_fir_filter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_fir_filter_unit
// Direct-form FIR filter over interleaved multichannel audio, one shared MAC.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one operation per transaction: a sample for the
//   current channel, a coefficient write or a history clear. Channels are
//   interleaved; each has its own history ring. Configuration (channel count,
//   tap count, latency frames) is written through the plain write port while
//   the block is idle.
//   A sample transaction walks n = min(tap_count, valid_frames + 1) taps, one
//   tap per cycle through the single multiply-accumulate unit. The filtered
//   sample appears at the output and the input is ready again in the same
//   cycle; no new sample is accepted until the last one is through the MAC.
//   Coefficient and clear transactions leave the block idle and ready.
//   Results wait in an output register; if the receiver stalls, the next
//   sample is still accepted and computed, and the block holds off further
//   input only when a second result would have nowhere to go.
//   Reset clears the counters and the registers (one channel, one tap, no
//   latency drop); coefficients must be written before use and history reads
//   as empty until samples arrive.
// ----------------------------------------------------------------------------
module multichannel_fir_filter_unit
    import mfir_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mfir_in_if.sink               i_in,
    mfir_out_if.source            o_out
);
    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer and counters.
    mfir_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in.valid),
        .i_in_func      (i_in.func),
        .i_in_tap_index (i_in.tap_index),
        .o_in_ready     (i_in.ready),
        .i_sts          (sts),
        .o_cmd          (cmd)
    );

    // Memories, MAC and output register.
    mfir_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_sample_in  (i_in.sample_in),
        .i_coef_value (i_in.coef_value),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_sample_out (o_out.sample_out),
        .o_channel    (o_out.channel)
    );
endmodule
